// ----- src/thermal_power_backoff_controller_unit_defines.svh -----
// Assertion macros shared by the thermal power backoff controller RTL.
`ifndef THERMAL_POWER_BACKOFF_CONTROLLER_UNIT_DEFINES_SVH
`define THERMAL_POWER_BACKOFF_CONTROLLER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every rising clock edge outside of reset.
`define TPBC_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("tpbc assertion failed");
// Check a property on every rising clock edge, reset included.
`define TPBC_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) (prop)) \
      else $error("tpbc assertion failed");
`else
`define TPBC_ASSERT(name, clk, rst, prop)
`define TPBC_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

// ----- src/tpbc_pkg.sv -----
// Types, codes and constants of the thermal power backoff controller.
package tpbc_pkg;

   localparam int SENSORS_DEFAULT = 8;

   localparam int NUM_W  = 46;
   localparam int PROD_W = 44;
   localparam int DIV_STEPS = 16;

   localparam logic [16:0] RATIO_ONE = 17'h10000;
   localparam logic [23:0] MAX24     = 24'hFFFFFF;

   typedef enum logic [1:0] {
      CMD_START    = 2'd0,
      CMD_SAMPLE   = 2'd1,
      CMD_EXTENDED = 2'd2,
      CMD_IGNORE   = 2'd3
   } cmd_type;

   localparam logic [1:0] STG_INITIAL = 2'd0;
   localparam logic [1:0] STG_SLOW    = 2'd1;
   localparam logic [1:0] STG_STABLE  = 2'd2;

   localparam logic [2:0] CSR_STEP_SIZE  = 3'd0;
   localparam logic [2:0] CSR_MAX_ATT    = 3'd1;
   localparam logic [2:0] CSR_EXTRA_ATT  = 3'd2;
   localparam logic [2:0] CSR_MIN_TICK   = 3'd3;
   localparam logic [2:0] CSR_RAMP       = 3'd4;
   localparam logic [2:0] CSR_HOLD_LIMIT = 3'd5;
   localparam logic [2:0] CSR_TEMP_SPAN  = 3'd6;
   localparam logic [2:0] CSR_EXT_ENABLE = 3'd7;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_MUL_INT,
      ST_ACC,
      ST_GATE,
      ST_MUL_P1,
      ST_MUL_P2,
      ST_MUL_P3,
      ST_MUL_P4,
      ST_MUL_P5,
      ST_RATIO,
      ST_DIV,
      ST_SCALE,
      ST_SCALE_DONE,
      ST_WRITE,
      ST_CLOSE,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [1:0]         stage;
      logic               active;
      logic [15:0]        backoff;
      logic [23:0]        slow;
      logic [23:0]        hold;
      logic signed [31:0] integ;
      logic               gate;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

// ----- src/tpbc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tpbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/thermal_power_backoff_controller_unit.sv -----
// Top level of the per-channel thermal power backoff controller.
//
// req_ carries one sensor sample per request: tuser holds the command, tlast
// closes the tick. Start requests (re)arm every sensor and give no result.
// A sample of a sensor is a read-modify-write of its entry in the sensor RAM
// (registered read) followed by the stage arithmetic on one shared 19x25
// multiplier and a 16-step restoring divider. Where a ratio is needed,
// initial and stable control divide directly; slow decrease first forms
// numerator and denominator on the multiplier. In extended mode, a closing
// extended request computes an extra ratio on the same divider.
// One request is worked on at a time; req_tready is high while idle.
// rsp_ delivers one result per closed tick from an output register, so the
// next request is taken while a result waits. If the receiver stalls, the
// next result holds in the sequencer until the register frees.
// csr_ writes a register, csr_ready is always high; write it
// only while the block is idle.
// Reset restores register defaults and marks every sensor entry unwritten,
// which reads as all zero; no clearing pass is needed.
`include "thermal_power_backoff_controller_unit_defines.svh"

module thermal_power_backoff_controller_unit #(
   parameter int SENSORS = tpbc_pkg::SENSORS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // sensor_slot[2:0], temperature[18:3], hot_limit[34:19],
   // extreme_limit[50:35], normal_limit[66:51], integral_limit[86:67]
   input  logic [87:0] req_tdata,
   // cmd[1:0]
   input  logic [1:0]  req_tuser,
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // channel_backoff_db[14:0], target_backoff_db[29:15]
   output logic [31:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int AW = (SENSORS > 1) ? $clog2(SENSORS) : 1;
   localparam logic [5:0] SENSORS_N = 6'(SENSORS);
   localparam int NW = tpbc_pkg::NUM_W;
   localparam int PW = tpbc_pkg::PROD_W;

   // configuration
   logic [13:0] step_ff, matt_ff, xatt_ff;
   logic [15:0] mpt_ff, ramp_ff, htl_ff;
   logic [14:0] span_ff;
   logic        exten_ff;

   // control and datapath
   tpbc_pkg::state_type state_ff, state_in;
   tpbc_pkg::cmd_type   cmd_ff, cmd_in;
   logic [2:0]          slot_ff, slot_in;
   logic signed [15:0]  t_ff, t_in, hot_ff, hot_in, eth_ff, eth_in, nth_ff, nth_in;
   logic [19:0]         ilim_ff, ilim_in;
   logic                last_ff, last_in;
   tpbc_pkg::entry_type ent_ff, ent_in;
   logic [SENSORS-1:0]  valid_ff, valid_in, pend_ff, pend_in;
   logic signed [NW-1:0] num_ff, num_in, den_ff, den_in;
   logic [NW-1:0]       rem_ff, rem_in;
   logic [16:0]         quo_ff, quo_in;
   logic [4:0]          cnt_ff, cnt_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic                ext_ff, ext_in;
   logic [15:0]         tmax_ff, tmax_in, chan_ff, chan_in, target_ff, target_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [31:0]         rsp_data_ff, rsp_data_in;

   // request fields
   tpbc_pkg::cmd_type  req_cmd;
   logic [2:0]         req_slot;
   logic signed [15:0] req_t, req_eth;
   logic               req_fire, req_slot_ok;
   logic [7:0]         req_slot_wide, slot_wide;
   logic [AW-1:0]      addr;

   // ram
   logic                      ram_we;
   logic [tpbc_pkg::ENTRY_W-1:0] ram_rd_data;

   // shared arithmetic
   logic signed [18:0] mul_a;
   logic signed [24:0] mul_b;
   logic signed [16:0] d_th, d_tn, d_eh, d_hn;
   logic signed [18:0] d_mix;
   logic [15:0]        ramp_eff;
   logic [23:0]        q_val;
   logic [NW-1:0]      den_u;

   assign req_cmd     = tpbc_pkg::cmd_type'(req_tuser);
   assign req_slot    = req_tdata[2:0];
   assign req_t       = $signed(req_tdata[18:3]);
   assign req_eth     = $signed(req_tdata[50:35]);
   assign req_fire    = req_tvalid && req_tready;
   assign req_slot_wide = 8'(req_slot);
   assign slot_wide   = 8'(slot_ff);
   assign req_slot_ok = 6'(req_slot) < SENSORS_N;
   assign addr        = slot_wide[AW-1:0];

   assign req_tready  = (state_ff == tpbc_pkg::ST_IDLE);
   assign csr_ready   = 1'b1;
   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_tdata   = rsp_data_ff;

   assign ram_we = (state_ff == tpbc_pkg::ST_WRITE);

   tpbc_ram #(
      .WIDTH(tpbc_pkg::ENTRY_W),
      .DEPTH(SENSORS)
   ) u_sensor_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(addr),
      .wr_data(ent_ff),
      .rd_addr(req_slot_wide[AW-1:0]),
      .rd_data(ram_rd_data)
   );

   assign d_th  = 17'(t_ff) - 17'(hot_ff);
   assign d_tn  = 17'(t_ff) - 17'(nth_ff);
   assign d_eh  = 17'(eth_ff) - 17'(hot_ff);
   assign d_hn  = 17'(hot_ff) - 17'(nth_ff);
   assign d_mix = 19'(eth_ff) + 19'(nth_ff) - 19'(hot_ff) - 19'(hot_ff);
   assign ramp_eff = (ramp_ff == 16'd0) ? 16'd1 : ramp_ff;
   assign q_val = {ramp_eff, 8'h00};
   assign den_u = NW'(den_ff);

   // operand select of the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         tpbc_pkg::ST_MUL_INT: begin
            mul_a = 19'(d_tn);
            mul_b = $signed({9'd0, mpt_ff});
         end
         tpbc_pkg::ST_MUL_P1: begin
            mul_a = 19'(d_th);
            mul_b = $signed({1'b0, q_val});
         end
         tpbc_pkg::ST_MUL_P2: begin
            mul_a = 19'(d_hn);
            mul_b = $signed({1'b0, ent_ff.slow});
         end
         tpbc_pkg::ST_MUL_P3: begin
            mul_a = 19'(d_eh);
            mul_b = $signed({1'b0, q_val});
         end
         tpbc_pkg::ST_MUL_P4: begin
            mul_a = d_mix;
            mul_b = $signed({1'b0, ent_ff.slow});
         end
         tpbc_pkg::ST_SCALE: begin
            mul_a = $signed({2'b00, quo_ff});
            mul_b = $signed({11'd0, ext_ff ? xatt_ff : matt_ff});
         end
         default: begin
            mul_a = '0;
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   // sequencer
   always_comb begin
      logic signed [16:0] over;
      logic [24:0]        sum25;
      logic signed [35:0] acc;
      logic               gate_now;
      logic [NW-1:0]      rem2;
      logic [13:0]        val;
      logic [16:0]        diff;
      logic [16:0]        stepped;
      logic               out_load;

      state_in   = state_ff;
      cmd_in     = cmd_ff;
      slot_in    = slot_ff;
      t_in       = t_ff;
      hot_in     = hot_ff;
      eth_in     = eth_ff;
      nth_in     = nth_ff;
      ilim_in    = ilim_ff;
      last_in    = last_ff;
      ent_in     = ent_ff;
      valid_in   = valid_ff;
      pend_in    = pend_ff;
      num_in     = num_ff;
      den_in     = den_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      cnt_in     = cnt_ff;
      ext_in     = ext_ff;
      tmax_in    = tmax_ff;
      chan_in    = chan_ff;
      target_in  = target_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      over     = 17'(req_t) - 17'(req_eth);
      sum25    = '0;
      acc      = '0;
      gate_now = ent_ff.gate;
      rem2     = {rem_ff[NW-2:0], 1'b0};
      val      = prod_ff[29:16];
      diff     = '0;
      stepped  = 17'(chan_ff);
      out_load = 1'b0;

      case (state_ff)
         tpbc_pkg::ST_IDLE: begin
            if (req_fire) begin
               cmd_in  = req_cmd;
               slot_in = req_slot;
               t_in    = req_t;
               hot_in  = $signed(req_tdata[34:19]);
               eth_in  = req_eth;
               nth_in  = $signed(req_tdata[66:51]);
               ilim_in = req_tdata[86:67];
               last_in = req_tlast;
               ext_in  = 1'b0;
               case (req_cmd)
                  tpbc_pkg::CMD_START: begin
                     pend_in = '1;
                  end
                  tpbc_pkg::CMD_SAMPLE: begin
                     if (req_slot_ok) begin
                        state_in = tpbc_pkg::ST_READ;
                     end else if (req_tlast) begin
                        state_in = tpbc_pkg::ST_CLOSE;
                     end
                  end
                  tpbc_pkg::CMD_EXTENDED: begin
                     if (exten_ff && over > 17'sd0 && over[15:0] > tmax_ff) begin
                        tmax_in = over[15:0];
                     end
                     if (req_tlast) begin
                        state_in = tpbc_pkg::ST_CLOSE;
                     end
                  end
                  default: begin
                     state_in = tpbc_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         tpbc_pkg::ST_READ: begin
            ent_in = tpbc_pkg::entry_type'(ram_rd_data);
            if (!valid_ff[addr]) begin
               ent_in = '0;
            end
            if (pend_ff[addr]) begin
               ent_in.stage  = tpbc_pkg::STG_INITIAL;
               ent_in.active = 1'b1;
            end
            state_in = tpbc_pkg::ST_EVAL;
         end
         tpbc_pkg::ST_EVAL: begin
            state_in = tpbc_pkg::ST_WRITE;
            if (ent_ff.active) begin
               case (ent_ff.stage)
                  tpbc_pkg::STG_INITIAL: begin
                     if (t_ff > hot_ff) begin
                        num_in   = NW'(d_th);
                        den_in   = NW'(d_eh);
                        state_in = tpbc_pkg::ST_RATIO;
                     end else begin
                        ent_in.stage = tpbc_pkg::STG_SLOW;
                        ent_in.slow  = '0;
                        ent_in.hold  = '0;
                        ent_in.integ = '0;
                        ent_in.gate  = 1'b0;
                     end
                  end
                  tpbc_pkg::STG_SLOW: begin
                     if (mpt_ff != 16'd0) begin
                        sum25 = 25'(ent_ff.slow) + 25'(mpt_ff);
                        ent_in.slow = (sum25 > 25'(tpbc_pkg::MAX24)) ?
                                      tpbc_pkg::MAX24 : sum25[23:0];
                        if (!ent_ff.gate) begin
                           sum25 = 25'(ent_ff.hold) + 25'(mpt_ff);
                           ent_in.hold = (sum25 > 25'(tpbc_pkg::MAX24)) ?
                                         tpbc_pkg::MAX24 : sum25[23:0];
                        end
                        state_in = tpbc_pkg::ST_MUL_INT;
                     end else begin
                        state_in = tpbc_pkg::ST_GATE;
                     end
                  end
                  tpbc_pkg::STG_STABLE: begin
                     if (t_ff > nth_ff) begin
                        if (nth_ff > 16'sd0) begin
                           num_in   = NW'(d_tn);
                           den_in   = NW'(nth_ff);
                           state_in = tpbc_pkg::ST_RATIO;
                        end else begin
                           ent_in.backoff = '0;
                        end
                     end else begin
                        ent_in.backoff = '0;
                        ent_in.active  = 1'b0;
                     end
                  end
                  default: begin
                     // unknown stage: keep the backoff
                     state_in = tpbc_pkg::ST_WRITE;
                  end
               endcase
            end
         end
         tpbc_pkg::ST_MUL_INT: begin
            state_in = tpbc_pkg::ST_ACC;
         end
         tpbc_pkg::ST_ACC: begin
            if (!ent_ff.gate) begin
               acc = 36'(ent_ff.integ) + 36'(prod_ff);
               if (acc > 36'sd2147483647) begin
                  ent_in.integ = 32'sh7FFFFFFF;
               end else if (acc < -36'sd2147483648) begin
                  ent_in.integ = 32'sh80000000;
               end else begin
                  ent_in.integ = acc[31:0];
               end
            end
            state_in = tpbc_pkg::ST_GATE;
         end
         tpbc_pkg::ST_GATE: begin
            if (!ent_ff.gate &&
                (ent_ff.integ > $signed({5'd0, ilim_ff, 8'h00}) ||
                 ent_ff.hold > {htl_ff, 8'h00})) begin
               gate_now = 1'b1;
            end
            ent_in.gate = gate_now;
            state_in = gate_now ? tpbc_pkg::ST_MUL_P1 : tpbc_pkg::ST_WRITE;
         end
         tpbc_pkg::ST_MUL_P1: begin
            state_in = tpbc_pkg::ST_MUL_P2;
         end
         tpbc_pkg::ST_MUL_P2: begin
            num_in   = NW'(prod_ff);
            state_in = tpbc_pkg::ST_MUL_P3;
         end
         tpbc_pkg::ST_MUL_P3: begin
            num_in   = num_ff + NW'(prod_ff);
            state_in = tpbc_pkg::ST_MUL_P4;
         end
         tpbc_pkg::ST_MUL_P4: begin
            den_in   = NW'(prod_ff);
            state_in = tpbc_pkg::ST_MUL_P5;
         end
         tpbc_pkg::ST_MUL_P5: begin
            den_in = den_ff - NW'(prod_ff);
            if (ent_ff.slow >= q_val) begin
               ent_in.stage = tpbc_pkg::STG_STABLE;
            end
            state_in = tpbc_pkg::ST_RATIO;
         end
         tpbc_pkg::ST_RATIO: begin
            if (den_ff <= 0 || num_ff <= 0) begin
               quo_in   = '0;
               state_in = tpbc_pkg::ST_SCALE;
            end else if (num_ff >= den_ff) begin
               quo_in   = tpbc_pkg::RATIO_ONE;
               state_in = tpbc_pkg::ST_SCALE;
            end else begin
               rem_in   = NW'(num_ff);
               quo_in   = '0;
               cnt_in   = 5'(tpbc_pkg::DIV_STEPS);
               state_in = tpbc_pkg::ST_DIV;
            end
         end
         tpbc_pkg::ST_DIV: begin
            if (rem2 >= den_u) begin
               rem_in = rem2 - den_u;
               quo_in = {quo_ff[15:0], 1'b1};
            end else begin
               rem_in = rem2;
               quo_in = {quo_ff[15:0], 1'b0};
            end
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd1) begin
               state_in = tpbc_pkg::ST_SCALE;
            end
         end
         tpbc_pkg::ST_SCALE: begin
            state_in = tpbc_pkg::ST_SCALE_DONE;
         end
         tpbc_pkg::ST_SCALE_DONE: begin
            if (ext_ff) begin
               target_in = 16'(matt_ff) + 16'(val);
               state_in  = tpbc_pkg::ST_OUT;
            end else begin
               ent_in.backoff = 16'(val);
               state_in = tpbc_pkg::ST_WRITE;
            end
         end
         tpbc_pkg::ST_WRITE: begin
            valid_in[addr] = 1'b1;
            pend_in[addr]  = 1'b0;
            if (ent_ff.backoff > tmax_ff) begin
               tmax_in = ent_ff.backoff;
            end
            state_in = last_ff ? tpbc_pkg::ST_CLOSE : tpbc_pkg::ST_IDLE;
         end
         tpbc_pkg::ST_CLOSE: begin
            if (cmd_ff == tpbc_pkg::CMD_SAMPLE) begin
               target_in = tmax_ff;
               state_in  = tpbc_pkg::ST_OUT;
            end else if (exten_ff) begin
               ext_in = 1'b1;
               if (span_ff == 15'd0) begin
                  quo_in   = (tmax_ff != 16'd0) ? tpbc_pkg::RATIO_ONE : 17'd0;
                  state_in = tpbc_pkg::ST_SCALE;
               end else begin
                  num_in   = NW'(tmax_ff);
                  den_in   = NW'(span_ff);
                  state_in = tpbc_pkg::ST_RATIO;
               end
            end else begin
               // extended mode off: hold the channel
               target_in = chan_ff;
               state_in  = tpbc_pkg::ST_OUT;
            end
         end
         tpbc_pkg::ST_OUT: begin
            if (target_ff > chan_ff) begin
               diff    = 17'(target_ff) - 17'(chan_ff);
               stepped = (diff > 17'(step_ff)) ? 17'(chan_ff) + 17'(step_ff)
                                               : 17'(target_ff);
            end else if (target_ff < chan_ff) begin
               diff    = 17'(chan_ff) - 17'(target_ff);
               stepped = (diff > 17'(step_ff)) ? 17'(chan_ff) - 17'(step_ff)
                                               : 17'(target_ff);
            end
            out_load = !rsp_valid_ff || rsp_tready;
            if (out_load) begin
               chan_in      = stepped[15:0];
               tmax_in      = '0;
               rsp_valid_in = 1'b1;
               rsp_data_in  = {2'b00, target_ff[14:0], stepped[14:0]};
               state_in     = tpbc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tpbc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tpbc_pkg::ST_IDLE;
         valid_ff     <= '0;
         pend_ff      <= '0;
         tmax_ff      <= '0;
         chan_ff      <= '0;
         ext_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= 14'd256;
         matt_ff      <= 14'd2560;
         xatt_ff      <= 14'd1280;
         mpt_ff       <= 16'd256;
         ramp_ff      <= 16'd30;
         htl_ff       <= 16'd10;
         span_ff      <= 15'd160;
         exten_ff     <= 1'b1;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         pend_ff      <= pend_in;
         tmax_ff      <= tmax_in;
         chan_ff      <= chan_in;
         ext_ff       <= ext_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               tpbc_pkg::CSR_STEP_SIZE:  step_ff  <= csr_data[13:0];
               tpbc_pkg::CSR_MAX_ATT:    matt_ff  <= csr_data[13:0];
               tpbc_pkg::CSR_EXTRA_ATT:  xatt_ff  <= csr_data[13:0];
               tpbc_pkg::CSR_MIN_TICK:   mpt_ff   <= csr_data;
               tpbc_pkg::CSR_RAMP:       ramp_ff  <= csr_data;
               tpbc_pkg::CSR_HOLD_LIMIT: htl_ff   <= csr_data;
               tpbc_pkg::CSR_TEMP_SPAN:  span_ff  <= csr_data[14:0];
               tpbc_pkg::CSR_EXT_ENABLE: exten_ff <= csr_data[0];
               default:                  exten_ff <= exten_ff;
            endcase
         end
      end
      cmd_ff      <= cmd_in;
      slot_ff     <= slot_in;
      t_ff        <= t_in;
      hot_ff      <= hot_in;
      eth_ff      <= eth_in;
      nth_ff      <= nth_in;
      ilim_ff     <= ilim_in;
      last_ff     <= last_in;
      ent_ff      <= ent_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      cnt_ff      <= cnt_in;
      prod_ff     <= prod_in;
      target_ff   <= target_in;
      rsp_data_ff <= rsp_data_in;
   end

   `TPBC_ASSERT(a_sample_reads_entry, clock, reset, (req_fire && req_cmd == tpbc_pkg::CMD_SAMPLE && req_slot_ok) |=> (state_ff == tpbc_pkg::ST_READ))
   `TPBC_ASSERT(a_div_in_range, clock, reset, (state_ff == tpbc_pkg::ST_DIV) |-> (cnt_ff != 5'd0 && rem_ff < den_u))
   `TPBC_ASSERT(a_result_from_out, clock, reset, (rsp_valid_ff && !$past(rsp_valid_ff)) |-> ($past(state_ff) == tpbc_pkg::ST_OUT))

endmodule
